/* design/vnt_pkg.sv */
// vnt_pkg: shared constants, widths and types of the vertex/normal transform.
// Used by every module in the design folder; depends on nothing.
package vnt_pkg;

    // number format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SAT_W       = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int CW          = 32;

    // configuration registers
    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam logic [CFG_COUNT-1:0][CFG_W-1:0] CFG_RESET = {
        64'h0000_0000_0001_0000,   // row2_col2_shift
        64'h0000_0000_0000_0000,   // row2_cols01
        64'h0000_0000_0000_0000,   // row1_col2_shift
        64'h0001_0000_0000_0000,   // row1_cols01
        64'h0000_0000_0000_0000,   // row0_col2_shift
        64'h0000_0000_0001_0000    // row0_cols01
    };

    // normal path widths
    localparam int COF_W       = 2 * CW;
    localparam int VEC_W       = COF_W + CW + 2;
    localparam int MAG_W       = VEC_W - 1;
    localparam int A_W         = 30;
    localparam int L2_W        = 2 * A_W + 2;
    localparam int ROOT_W      = L2_W / 2;
    localparam int RECIP_SHIFT = 61;
    localparam int RS_W        = RECIP_SHIFT + 1;

    // iterative units
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = (RS_W + DIV_STEPS - 1) / DIV_STEPS;

    typedef enum logic {
        FUNC_POSITION,
        FUNC_NORMAL
    } t_func;

    typedef struct packed {
        logic [2:0][2:0][CW-1:0] m;
        logic [2:0][CW-1:0]      t;
    } t_matrix;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_det_flags;

    // per-transaction data carried alongside the square root and reciprocal
    typedef struct packed {
        t_func                  func;
        logic [2:0][CW-1:0]     pos;
        logic                   sat;
        logic                   inval;
        logic [2:0]             neg;
        logic [2:0][A_W-1:0]    a;
    } t_side;

endpackage

/* design/vnt_cofactor.sv */
// vnt_cofactor: cofactor matrix and determinant sign/zero flags of the
// configured 3x3 matrix, five register stages. Depends on vnt_pkg.
module vnt_cofactor (
    input  logic                                       i_clk,
    input  vnt_pkg::t_matrix                           i_mat,
    output logic [2:0][2:0][vnt_pkg::COF_W-1:0]        o_cof,
    output vnt_pkg::t_det_flags                        o_det
);
    localparam int VW = vnt_pkg::VEC_W;
    localparam int HW = vnt_pkg::CW;

    logic signed [vnt_pkg::COF_W-1:0] r_pa [3][3];
    logic signed [vnt_pkg::COF_W-1:0] r_pb [3][3];
    logic signed [vnt_pkg::COF_W-1:0] r_cof [3][3];
    logic signed [vnt_pkg::COF_W:0]   r_dlo [3];
    logic signed [vnt_pkg::COF_W-1:0] r_dhi [3];
    logic signed [VW-1:0]             r_det;
    logic signed [VW-1:0]             n_det;
    vnt_pkg::t_det_flags              r_det_flags;

    // two 2x2 products and their difference for each cofactor
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int I1 = (gi + 1) % 3;
            localparam int I2 = (gi + 2) % 3;
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            always_ff @(posedge i_clk) begin
                r_pa[gi][gj]  <= $signed(i_mat.m[I1][J1]) * $signed(i_mat.m[I2][J2]);
                r_pb[gi][gj]  <= $signed(i_mat.m[I1][J2]) * $signed(i_mat.m[I2][J1]);
                r_cof[gi][gj] <= r_pa[gi][gj] - r_pb[gi][gj];
            end
            assign o_cof[gi][gj] = r_cof[gi][gj];
        end
    end

    // first-row expansion, cofactor split into halves
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_dlo[j] <= $signed(i_mat.m[0][j]) * $signed({1'b0, r_cof[0][j][HW-1:0]});
            r_dhi[j] <= $signed(i_mat.m[0][j]) * $signed(r_cof[0][j][2*HW-1:HW]);
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (VW'(r_dhi[j]) <<< HW) + VW'(r_dlo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det            <= n_det;
        r_det_flags.zero <= (r_det == '0);
        r_det_flags.neg  <= r_det[VW-1];
    end

    assign o_det = r_det_flags;

endmodule

/* design/vnt_isqrt.sv */
// vnt_isqrt: pipelined integer square root, two result bits per stage,
// with the transaction's side data carried along. Depends on vnt_pkg.
module vnt_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  vnt_pkg::t_side               i_side,
    input  logic [vnt_pkg::L2_W-1:0]     i_l2,
    output logic                         o_valid,
    output vnt_pkg::t_side               o_side,
    output logic [vnt_pkg::ROOT_W-1:0]   o_root
);
    localparam int N     = vnt_pkg::SQRT_STAGES;
    localparam int STEPS = vnt_pkg::SQRT_STEPS;
    localparam int RW    = vnt_pkg::ROOT_W;
    localparam int LW    = vnt_pkg::L2_W;
    localparam int TW    = LW + 2;

    logic           r_valid [N];
    vnt_pkg::t_side r_side  [N];
    logic [LW-1:0]  r_rem   [N];
    logic [RW-1:0]  r_root  [N];

    for (genvar gs = 0; gs < N; gs++) begin : g_stage
        logic           w_valid;
        vnt_pkg::t_side w_side;
        logic [LW-1:0]  w_rem;
        logic [RW-1:0]  w_root;
        logic [LW-1:0]  n_rem;
        logic [RW-1:0]  n_root;

        if (gs == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_side  = i_side;
            assign w_rem   = i_l2;
            assign w_root  = '0;
        end else begin : g_next
            assign w_valid = r_valid[gs-1];
            assign w_side  = r_side[gs-1];
            assign w_rem   = r_rem[gs-1];
            assign w_root  = r_root[gs-1];
        end

        // try each root bit: keep it if (root + 2^b)^2 still fits
        always_comb begin
            logic [TW-1:0] rem;
            logic [TW-1:0] test;
            logic [RW-1:0] root;
            int            b;
            rem  = TW'(w_rem);
            root = w_root;
            test = '0;
            b    = 0;
            for (int st = 0; st < STEPS; st++) begin
                b = RW - 1 - gs * STEPS - st;
                if (b >= 0) begin
                    test = (TW'(root) << (b + 1)) + (TW'(1) << (2 * b));
                    if (rem >= test) begin
                        rem  = rem - test;
                        root = root | (RW'(1) << b);
                    end
                end
            end
            n_rem  = rem[LW-1:0];
            n_root = root;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[gs] <= 1'b0;
            end else if (i_en) begin
                r_valid[gs] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[gs] <= w_side;
                r_rem[gs]  <= n_rem;
                r_root[gs] <= n_root;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_side  = r_side[N-1];
    assign o_root  = r_root[N-1];

endmodule

/* design/vnt_recip.sv */
// vnt_recip: pipelined restoring divider giving floor(2^61 / q), four
// quotient bits per stage, side data carried along. Depends on vnt_pkg.
module vnt_recip (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  vnt_pkg::t_side               i_side,
    input  logic [vnt_pkg::ROOT_W-1:0]   i_q,
    output logic                         o_valid,
    output vnt_pkg::t_side               o_side,
    output logic [vnt_pkg::RS_W-1:0]     o_rs
);
    localparam int N     = vnt_pkg::DIV_STAGES;
    localparam int STEPS = vnt_pkg::DIV_STEPS;
    localparam int QW    = vnt_pkg::ROOT_W;
    localparam int DW    = QW + 1;
    localparam int SW    = vnt_pkg::RS_W;

    logic           r_valid [N];
    vnt_pkg::t_side r_side  [N];
    logic [QW-1:0]  r_q     [N];
    logic [DW-1:0]  r_rem   [N];
    logic [SW-1:0]  r_quo   [N];

    for (genvar gs = 0; gs < N; gs++) begin : g_stage
        logic           w_valid;
        vnt_pkg::t_side w_side;
        logic [QW-1:0]  w_q;
        logic [DW-1:0]  w_rem;
        logic [SW-1:0]  w_quo;
        logic [DW-1:0]  n_rem;
        logic [SW-1:0]  n_quo;

        if (gs == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_side  = i_side;
            assign w_q     = i_q;
            assign w_rem   = '0;
            assign w_quo   = '0;
        end else begin : g_next
            assign w_valid = r_valid[gs-1];
            assign w_side  = r_side[gs-1];
            assign w_q     = r_q[gs-1];
            assign w_rem   = r_rem[gs-1];
            assign w_quo   = r_quo[gs-1];
        end

        // shift in the next dividend bit (only the top one is set)
        always_comb begin
            logic [DW-1:0] rem;
            logic [SW-1:0] quo;
            int            b;
            rem = w_rem;
            quo = w_quo;
            b   = 0;
            for (int st = 0; st < STEPS; st++) begin
                b = SW - 1 - gs * STEPS - st;
                if (b >= 0) begin
                    rem = {rem[DW-2:0], (b == vnt_pkg::RECIP_SHIFT) ? 1'b1 : 1'b0};
                    if (rem >= DW'(w_q)) begin
                        rem = rem - DW'(w_q);
                        quo = quo | (SW'(1) << b);
                    end
                end
            end
            n_rem = rem;
            n_quo = quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[gs] <= 1'b0;
            end else if (i_en) begin
                r_valid[gs] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[gs] <= w_side;
                r_q[gs]    <= w_q;
                r_rem[gs]  <= n_rem;
                r_quo[gs]  <= n_quo;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_side  = r_side[N-1];
    assign o_rs    = r_quo[N-1];

endmodule

/* design/vertex_normal_transform.sv */
// vertex_normal_transform: affine position and normal transform, Q16.16.
// Throughput: one transaction per cycle; the 45-stage pipeline (10 front stages,
// 16 square-root stages, 16 reciprocal stages, 3 back stages) only halts while
// the output register holds an untaken result. Reset clears all valid bits and
// loads the identity matrix; config changes reach the normal path through the
// registers of the cofactor unit.
module vertex_normal_transform (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vnt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vnt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic signed [vnt_pkg::CW-1:0]      i_in_x,
    input  logic signed [vnt_pkg::CW-1:0]      i_in_y,
    input  logic signed [vnt_pkg::CW-1:0]      i_in_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [vnt_pkg::CW-1:0]      o_out_x,
    output logic signed [vnt_pkg::CW-1:0]      o_out_y,
    output logic signed [vnt_pkg::CW-1:0]      o_out_z,
    output logic                               o_saturated,
    output logic                               o_invalid
);
    localparam int F      = vnt_pkg::FRAC_BITS;
    localparam int CW     = vnt_pkg::CW;
    localparam int VW     = vnt_pkg::VEC_W;
    localparam int MW     = vnt_pkg::MAG_W;
    localparam int AW     = vnt_pkg::A_W;
    localparam int LW     = vnt_pkg::L2_W;
    localparam int SQW    = 2 * AW;
    localparam int PSUM_W = 2 * CW + 2;
    localparam int POS_W  = PSUM_W - F + 1;
    localparam int NG     = (MW + 7) / 8;
    localparam int KW     = $clog2(MW);
    localparam int RSLW   = vnt_pkg::RS_W / 2;
    localparam int RSHW   = vnt_pkg::RS_W - RSLW;
    localparam int PPW    = AW + RSHW;
    localparam int PRW    = AW + vnt_pkg::RS_W;
    localparam int RSH    = vnt_pkg::RECIP_SHIFT;
    localparam logic signed [POS_W-1:0] POS_HI = (POS_W'(1) <<< (vnt_pkg::SAT_W - 1)) - 1;
    localparam logic signed [POS_W-1:0] POS_LO = -POS_HI - 1;

    // global advance: every pipeline stage moves unless the output is held
    logic w_en;
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // configuration registers
    logic [vnt_pkg::CFG_COUNT-1:0][vnt_pkg::CFG_W-1:0] r_cfg;
    vnt_pkg::t_matrix w_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= vnt_pkg::CFG_RESET;
        end else if (i_cfg_we &&
                     (i_cfg_index < vnt_pkg::CFG_IDX_W'(vnt_pkg::CFG_COUNT))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mat.m[i][0] = r_cfg[2*i][CW-1:0];
            w_mat.m[i][1] = r_cfg[2*i][2*CW-1:CW];
            w_mat.m[i][2] = r_cfg[2*i+1][CW-1:0];
            w_mat.t[i]    = r_cfg[2*i+1][2*CW-1:CW];
        end
    end

    // cofactors and determinant flags from the live matrix
    logic [2:0][2:0][vnt_pkg::COF_W-1:0] w_cof;
    vnt_pkg::t_det_flags                 w_det;

    vnt_cofactor u_cofactor (
        .i_clk (i_clk),
        .i_mat (w_mat),
        .o_cof (w_cof),
        .o_det (w_det)
    );

    // pipeline registers
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic r6_valid, r7_valid, r8_valid, r9_valid, r10_valid;
    logic rA_valid, rB_valid;

    vnt_pkg::t_func             r1_func, r2_func, r3_func;
    logic signed [CW-1:0]       r1_p [3];
    logic signed [CW-1:0]       r2_p [3];
    logic signed [2*CW-1:0]     r2_pp [3][3];
    logic signed [2*CW-1:0]     n2_pp [3][3];
    logic signed [2*CW:0]       r3_vlo [3][3];
    logic signed [2*CW:0]       n3_vlo [3][3];
    logic signed [2*CW-1:0]     r3_vhi [3][3];
    logic signed [2*CW-1:0]     n3_vhi [3][3];
    logic signed [POS_W-1:0]    r3_pos [3];
    logic signed [POS_W-1:0]    n3_pos [3];
    logic signed [VW-1:0]       r4_vec [3];
    logic signed [VW-1:0]       n4_vec [3];
    vnt_pkg::t_side             r4_side, n4_side;
    vnt_pkg::t_side             r5_side, r6_side, n6_side, r7_side, n7_side;
    vnt_pkg::t_side             r8_side, n8_side, r9_side, r10_side;
    logic [2:0]                 r5_sneg;
    logic [MW-1:0]              r5_mag [3];
    logic [MW-1:0]              n5_mag [3];
    logic [MW-1:0]              r6_mag [3];
    logic [MW-1:0]              r7_mag [3];
    logic [NG-1:0]              r6_gnz, n6_gnz;
    logic [2:0]                 r6_gpos [NG];
    logic [2:0]                 n6_gpos [NG];
    logic                       r6_nz, n6_nz;
    logic [KW-1:0]              r7_k, n7_k;
    logic [SQW-1:0]             r9_sq [3];
    logic [LW-1:0]              r10_l2;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r5_valid  <= 1'b0;
            r6_valid  <= 1'b0;
            r7_valid  <= 1'b0;
            r8_valid  <= 1'b0;
            r9_valid  <= 1'b0;
            r10_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid  <= i_in_valid;
            r2_valid  <= r1_valid;
            r3_valid  <= r2_valid;
            r4_valid  <= r3_valid;
            r5_valid  <= r4_valid;
            r6_valid  <= r5_valid;
            r7_valid  <= r6_valid;
            r8_valid  <= r7_valid;
            r9_valid  <= r8_valid;
            r10_valid <= r9_valid;
        end
    end

    // stage 2: position products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n2_pp[i][j] = $signed(w_mat.m[i][j]) * r1_p[j];
            end
        end
    end

    // stage 3: normal partial products, position rounding and translation
    always_comb begin
        logic signed [PSUM_W-1:0] psum;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n3_vlo[i][j] = $signed({1'b0, w_cof[i][j][CW-1:0]}) * r2_p[j];
                n3_vhi[i][j] = $signed(w_cof[i][j][2*CW-1:CW]) * r2_p[j];
            end
            psum = PSUM_W'(1) <<< (F - 1);
            for (int j = 0; j < 3; j++) begin
                psum = psum + PSUM_W'(r2_pp[i][j]);
            end
            n3_pos[i] = POS_W'(psum >>> F) + POS_W'($signed(w_mat.t[i]));
        end
    end

    // stage 4: clamp positions, sum normal products
    always_comb begin
        n4_side      = '0;
        n4_side.func = r3_func;
        for (int i = 0; i < 3; i++) begin
            if (r3_pos[i] > POS_HI) begin
                n4_side.pos[i] = POS_HI[CW-1:0];
                n4_side.sat    = 1'b1;
            end else if (r3_pos[i] < POS_LO) begin
                n4_side.pos[i] = POS_LO[CW-1:0];
                n4_side.sat    = 1'b1;
            end else begin
                n4_side.pos[i] = r3_pos[i][CW-1:0];
            end
            n4_vec[i] = '0;
            for (int j = 0; j < 3; j++) begin
                n4_vec[i] = n4_vec[i] + (VW'(r3_vhi[i][j]) <<< CW) + VW'(r3_vlo[i][j]);
            end
        end
    end

    // stage 5: magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_mag[i] = r4_vec[i][VW-1] ? MW'(-r4_vec[i]) : MW'(r4_vec[i]);
        end
    end

    // stage 6: signs against det, leading one per byte of the OR
    always_comb begin
        logic [NG*8-1:0] orv;
        orv     = (NG*8)'(r5_mag[0] | r5_mag[1] | r5_mag[2]);
        n6_nz   = |orv;
        n6_side = r5_side;
        n6_side.inval = w_det.zero;
        for (int i = 0; i < 3; i++) begin
            n6_side.neg[i] = r5_sneg[i] ^ w_det.neg;
        end
        for (int g = 0; g < NG; g++) begin
            n6_gnz[g]  = |orv[g*8 +: 8];
            n6_gpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (orv[g*8 + b]) begin
                    n6_gpos[g] = 3'(b);
                end
            end
        end
    end

    // stage 7: block-scale shift from the highest set bit
    always_comb begin
        logic [KW-1:0] msb;
        msb = '0;
        for (int g = 0; g < NG; g++) begin
            if (r6_gnz[g]) begin
                msb = KW'(g * 8) + KW'(r6_gpos[g]);
            end
        end
        n7_k    = (msb >= KW'(AW)) ? msb - KW'(AW - 1) : '0;
        n7_side = r6_side;
        n7_side.inval = r6_side.inval | !r6_nz;
    end

    // stage 8: scaled components
    always_comb begin
        n8_side = r7_side;
        for (int i = 0; i < 3; i++) begin
            n8_side.a[i] = AW'(r7_mag[i] >> r7_k);
        end
    end

    // front payload registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func <= vnt_pkg::t_func'(i_func);
            r1_p[0] <= i_in_x;
            r1_p[1] <= i_in_y;
            r1_p[2] <= i_in_z;
            r2_func <= r1_func;
            r2_p    <= r1_p;
            r2_pp   <= n2_pp;
            r3_func <= r2_func;
            r3_vlo  <= n3_vlo;
            r3_vhi  <= n3_vhi;
            r3_pos  <= n3_pos;
            r4_side <= n4_side;
            r4_vec  <= n4_vec;
            r5_side <= r4_side;
            r5_mag  <= n5_mag;
            for (int i = 0; i < 3; i++) begin
                r5_sneg[i] <= r4_vec[i][VW-1];
            end
            r6_side <= n6_side;
            r6_mag  <= r5_mag;
            r6_gnz  <= n6_gnz;
            r6_gpos <= n6_gpos;
            r6_nz   <= n6_nz;
            r7_side <= n7_side;
            r7_mag  <= r6_mag;
            r7_k    <= n7_k;
            r8_side <= n8_side;
            r9_side <= r8_side;
            for (int i = 0; i < 3; i++) begin
                r9_sq[i] <= SQW'(r8_side.a[i]) * SQW'(r8_side.a[i]);
            end
            r10_side <= r9_side;
            r10_l2   <= LW'(r9_sq[0]) + LW'(r9_sq[1]) + LW'(r9_sq[2]);
        end
    end

    // length and its reciprocal
    logic                             w_sq_valid, w_rc_valid;
    vnt_pkg::t_side                   w_sq_side, w_rc_side;
    logic [vnt_pkg::ROOT_W-1:0]       w_root;
    logic [vnt_pkg::RS_W-1:0]         w_rs;

    vnt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r10_valid),
        .i_side  (r10_side),
        .i_l2    (r10_l2),
        .o_valid (w_sq_valid),
        .o_side  (w_sq_side),
        .o_root  (w_root)
    );

    vnt_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_side  (w_sq_side),
        .i_q     (w_root),
        .o_valid (w_rc_valid),
        .o_side  (w_rc_side),
        .o_rs    (w_rs)
    );

    // back end: scale by reciprocal, round, select result
    vnt_pkg::t_side    rA_side, rB_side;
    logic [PPW-1:0]    rA_lo [3];
    logic [PPW-1:0]    rA_hi [3];
    logic [CW-1:0]     rB_mag [3];
    logic [CW-1:0]     nB_mag [3];
    logic              r_out_valid;
    logic [CW-1:0]     r_out_x, r_out_y, r_out_z, n_out_x, n_out_y, n_out_z;
    logic              r_out_sat, r_out_inval, n_out_sat, n_out_inval;

    always_comb begin
        logic [PRW-1:0] prod;
        for (int i = 0; i < 3; i++) begin
            prod = (PRW'(rA_hi[i]) << RSLW) + PRW'(rA_lo[i]) + (PRW'(1) << (RSH - 1 - F));
            nB_mag[i] = CW'(prod >> (RSH - F));
        end
    end

    always_comb begin
        n_out_x     = '0;
        n_out_y     = '0;
        n_out_z     = '0;
        n_out_sat   = 1'b0;
        n_out_inval = 1'b0;
        if (rB_side.func == vnt_pkg::FUNC_POSITION) begin
            n_out_x   = rB_side.pos[0];
            n_out_y   = rB_side.pos[1];
            n_out_z   = rB_side.pos[2];
            n_out_sat = rB_side.sat;
        end else if (rB_side.inval) begin
            n_out_inval = 1'b1;
        end else begin
            n_out_x = rB_side.neg[0] ? CW'(0) - rB_mag[0] : rB_mag[0];
            n_out_y = rB_side.neg[1] ? CW'(0) - rB_mag[1] : rB_mag[1];
            n_out_z = rB_side.neg[2] ? CW'(0) - rB_mag[2] : rB_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_valid    <= 1'b0;
            rB_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            rA_valid    <= w_rc_valid;
            rB_valid    <= rA_valid;
            r_out_valid <= rB_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rA_side <= w_rc_side;
            for (int i = 0; i < 3; i++) begin
                rA_lo[i] <= PPW'(w_rc_side.a[i]) * PPW'(w_rs[RSLW-1:0]);
                rA_hi[i] <= PPW'(w_rc_side.a[i]) * PPW'(w_rs[vnt_pkg::RS_W-1:RSLW]);
            end
            rB_side     <= rA_side;
            rB_mag      <= nB_mag;
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_z     <= n_out_z;
            r_out_sat   <= n_out_sat;
            r_out_inval <= n_out_inval;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_saturated = r_out_sat;
    assign o_invalid   = r_out_inval;

`ifndef SYNTHESIS
    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalid) |-> (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("invalid normal with non-zero components");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_saturated && o_invalid))
        else $error("saturated and invalid both set");
    a_hold_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(rB_valid))
        else $error("pipeline moved while output held");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && rB_valid) |=> o_out_valid)
        else $error("last stage transaction lost");
`endif

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for vertex_normal_transform (positions and normals).
// Depends on vnt_pkg and the design; drives random and directed vectors, checks in order.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [31:0] x, y, z;
        logic        sat, inval;
    } t_result;

    // expected-result store and comparison
    class transform_scoreboard;
        t_result pending[$];
        int      errors;

        function void note_input(t_result r);
            pending = {pending, r};
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%h", $time, got.x);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.x !== exp.x) begin
                $display("%0t: out_x exp %h got %h", $time, exp.x, got.x);
                errors++;
            end
            if (got.y !== exp.y) begin
                $display("%0t: out_y exp %h got %h", $time, exp.y, got.y);
                errors++;
            end
            if (got.z !== exp.z) begin
                $display("%0t: out_z exp %h got %h", $time, exp.z, got.z);
                errors++;
            end
            if (got.sat !== exp.sat) begin
                $display("%0t: saturated exp %b got %b", $time, exp.sat, got.sat);
                errors++;
            end
            if (got.inval !== exp.inval) begin
                $display("%0t: invalid exp %b got %b", $time, exp.inval, got.inval);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [vnt_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [vnt_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = 1'b0;
    logic signed [31:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic        o_saturated, o_invalid;

    transform_scoreboard sb;
    logic [63:0] matrix_regs[6];
    int          idle_cycles = 0;
    int          rx_wait;
    bit          stim_done;

    vertex_normal_transform u_dut (.*);

    always #1 i_clk = ~i_clk;

    // signed 32-bit field of a register
    function automatic logic signed [63:0] reg_half(int idx, bit hi);
        return hi ? 64'(signed'(matrix_regs[idx][63:32]))
                  : 64'(signed'(matrix_regs[idx][31:0]));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // expected result of one vector under the current matrix
    function automatic t_result transform_vector(vnt_pkg::t_func f, logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] pz);
        logic signed [63:0]  m[3][3], t[3], p[3], c[3][3];
        logic signed [127:0] det, s[3], v;
        logic [127:0]        mg[3], acc;
        logic [63:0]         a[3], l2, q, rs, r;
        bit                  ng[3], dneg;
        int                  k;
        t_result             res;
        res = '{0, 0, 0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            m[i][0] = reg_half(2 * i, 0);
            m[i][1] = reg_half(2 * i, 1);
            m[i][2] = reg_half(2 * i + 1, 0);
            t[i]    = reg_half(2 * i + 1, 1);
        end
        p[0] = px; p[1] = py; p[2] = pz;
        if (f == vnt_pkg::FUNC_POSITION) begin
            logic [31:0] o[3];
            for (int i = 0; i < 3; i++) begin
                v = 0;
                for (int j = 0; j < 3; j++) v += 128'(m[i][j]) * 128'(p[j]);
                v = ((v + (128'sd1 <<< (vnt_pkg::FRAC_BITS - 1))) >>> vnt_pkg::FRAC_BITS)
                    + 128'(t[i]);
                if (v > 128'sd2147483647) begin
                    v = 128'sd2147483647; res.sat = 1;
                end
                if (v < -128'sd2147483648) begin
                    v = -128'sd2147483648; res.sat = 1;
                end
                o[i] = v[31:0];
            end
            res.x = o[0]; res.y = o[1]; res.z = o[2];
            return res;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                        - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
        det = 0;
        for (int j = 0; j < 3; j++) det += 128'(m[0][j]) * 128'(c[0][j]);
        dneg = det < 0;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = 0;
            for (int j = 0; j < 3; j++) s[i] += 128'(c[i][j]) * 128'(p[j]);
            ng[i] = (s[i] < 0) != dneg;
            mg[i] = s[i] < 0 ? -s[i] : s[i];
            acc |= mg[i];
        end
        if (det == 0 || acc == 0) begin
            res.inval = 1;
            return res;
        end
        k = 0;
        while (acc >= (128'd1 << 30)) begin
            acc >>= 1; k++;
        end
        l2 = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = 64'(mg[i] >> k);
            l2 += a[i] * a[i];
        end
        q  = int_sqrt(l2);
        rs = (64'd1 << 61) / q;
        for (int i = 0; i < 3; i++) begin
            r = (a[i] * rs + (64'd1 << (60 - vnt_pkg::FRAC_BITS)))
                >> (61 - vnt_pkg::FRAC_BITS);
            a[i] = ng[i] ? -r : r;
        end
        res.x = a[0][31:0]; res.y = a[1][31:0]; res.z = a[2][31:0];
        return res;
    endfunction

    // one register write; the enable stays up until end_config
    task automatic write_reg(int idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[vnt_pkg::CFG_IDX_W-1:0];
        i_cfg_data  <= val;
        @(posedge i_clk);
        matrix_regs[idx] = val;
    endtask

    task automatic end_config();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until the pipeline has drained, then settle past the latency
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // one input transaction, with a random gap first
    task automatic send_vector(vnt_pkg::t_func f, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f; i_in_x <= x; i_in_y <= y; i_in_z <= z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(transform_vector(f, x, y, z));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'(signed'($urandom_range(0, 2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    function automatic logic [63:0] rand_reg();
        return {rand_coord(), rand_coord()};
    endfunction

    // receiver: check every accepted result, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result('{o_out_x, o_out_y, o_out_z, o_saturated, o_invalid});
            rx_wait = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
            idle_cycles <= rx_wait;
            i_out_stall <= (rx_wait != 0);
        end else if (idle_cycles > 1) begin
            idle_cycles <= idle_cycles - 1;
        end else begin
            idle_cycles <= 0;
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transaction
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 5000 && !stim_done) begin
            $display("vertex_normal_transform test failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] ext[4];
        sb = new();
        stim_done = 0;
        for (int i = 0; i < 6; i++) matrix_regs[i] = vnt_pkg::CFG_RESET[i];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, extremes, zero vector
        ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000};
        foreach (ext[i]) begin
            send_vector(vnt_pkg::FUNC_POSITION, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
            send_vector(vnt_pkg::FUNC_NORMAL, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
        end
        send_vector(vnt_pkg::FUNC_NORMAL, 0, 0, 0);
        drain_pipeline();
        // saturating matrix with big translation
        write_reg(0, 64'h7fff_ffff_7fff_ffff);
        write_reg(1, 64'h7fff_ffff_7fff_ffff);
        write_reg(2, 64'h8000_0000_8000_0000);
        write_reg(3, 64'h8000_0000_8000_0000);
        write_reg(4, 64'h0001_0000_0000_0000);
        write_reg(5, 64'h7fff_ffff_0000_0000);
        end_config();
        foreach (ext[i]) begin
            send_vector(vnt_pkg::FUNC_POSITION, ext[i], ext[(i+3)%4], ext[(i+1)%4]);
            send_vector(vnt_pkg::FUNC_NORMAL, ext[i], ext[(i+3)%4], ext[(i+1)%4]);
        end
        drain_pipeline();
        // singular matrix: two equal rows
        write_reg(0, 64'h0002_0000_0001_0000);
        write_reg(1, 64'h0000_0000_0003_0000);
        write_reg(2, 64'h0002_0000_0001_0000);
        write_reg(3, 64'h0000_0000_0003_0000);
        end_config();
        send_vector(vnt_pkg::FUNC_NORMAL, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
        send_vector(vnt_pkg::FUNC_POSITION, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
        drain_pipeline();

        // random phases with new matrices
        for (int ph = 0; ph < 19; ph++) begin
            for (int r = 0; r < 6; r++) write_reg(r, rand_reg());
            if (ph % 5 == 4) write_reg(4, {matrix_regs[0][63:32], matrix_regs[0][31:0]});
            end_config();
            for (int n = 0; n < 100; n++)
                send_vector(vnt_pkg::t_func'($urandom_range(0, 1)), rand_coord(),
                            rand_coord(), rand_coord());
            drain_pipeline();
        end
        stim_done = 1;

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("vertex_normal_transform test passed");
        end else begin
            $display("vertex_normal_transform test failed");
        end
        $finish;
    end
endmodule

/* vertex_normal_transform.f */
design/vnt_pkg.sv
design/vnt_cofactor.sv
design/vnt_isqrt.sv
design/vnt_recip.sv
design/vertex_normal_transform.sv
dv/tb.sv
